### rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types, step addresses and control-store contents for the heap sort
// engine: control word layout, branch conditions and the microprogram.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int unsigned HSE_MAX_ITEMS = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PC_W          = 5;

  typedef logic [PC_W-1:0] pc_t;

  // Step addresses of the microprogram
  localparam pc_t ST_IDLE     = 5'd0;
  localparam pc_t ST_CHK      = 5'd1;
  localparam pc_t ST_UP_READ  = 5'd2;
  localparam pc_t ST_UP_CMP   = 5'd3;
  localparam pc_t ST_UP_MOVE  = 5'd4;
  localparam pc_t ST_UP_PLACE = 5'd5;
  localparam pc_t ST_DROP     = 5'd6;
  localparam pc_t ST_LAST     = 5'd7;
  localparam pc_t ST_X_INIT   = 5'd8;
  localparam pc_t ST_X_READ   = 5'd9;
  localparam pc_t ST_X_SWAP   = 5'd10;
  localparam pc_t ST_DN_READ  = 5'd11;
  localparam pc_t ST_DN_CMP   = 5'd12;
  localparam pc_t ST_DN_MOVE  = 5'd13;
  localparam pc_t ST_DN_PLACE = 5'd14;
  localparam pc_t ST_EM_INIT  = 5'd15;
  localparam pc_t ST_EM_READ  = 5'd16;
  localparam pc_t ST_EM_LOAD  = 5'd17;
  localparam pc_t ST_FIN      = 5'd18;

  // Branch conditions: jump to target when true, else step to pc + 1
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_FULL,
    C_IDX_ZERO,
    C_NOT_GT,
    C_NOT_LAST,
    C_SMALL,
    C_NO_CHILD,
    C_NOT_GT_CHILD,
    C_OUT_BUSY,
    C_MORE
  } cond_e;

  typedef enum logic [1:0] {RA_PARENT, RA_ZERO, RA_CHILD_L, RA_IDX} ra_sel_e;
  typedef enum logic {RB_LAST_M, RB_CHILD_R} rb_sel_e;
  typedef enum logic {WA_IDX, WA_LAST_M} wa_sel_e;
  typedef enum logic [1:0] {WD_RDA, WD_ELEM, WD_CHILD} wd_sel_e;
  typedef enum logic [2:0] {IDX_HOLD, IDX_PARENT, IDX_ZERO, IDX_CHILD, IDX_INC} idx_op_e;
  typedef enum logic [1:0] {M_HOLD, M_LOAD, M_DEC} m_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_CLR} cnt_op_e;

  // One control word per step
  typedef struct packed {
    cond_e    cond;
    pc_t      target;
    logic     accept;
    ra_sel_e  ra_sel;
    logic     re_a;
    rb_sel_e  rb_sel;
    logic     re_b;
    logic     we;
    wa_sel_e  wa_sel;
    wd_sel_e  wd_sel;
    idx_op_e  idx_op;
    logic     elem_ld_rdb;
    m_op_e    m_op;
    cnt_op_e  cnt_op;
    logic     drop_set;
    logic     out_load;
  } hse_cw_t;

  // Status flags from the datapath, one per branch condition
  typedef struct packed {
    logic no_input;
    logic full;
    logic idx_zero;
    logic not_gt;
    logic not_last;
    logic small_heap;
    logic no_child;
    logic not_gt_child;
    logic out_busy;
    logic more;
  } hse_flags_t;

  // Control store
  function automatic hse_cw_t hse_rom(pc_t pc);
    hse_cw_t cw;
    cw = '{cond: C_NEVER, target: ST_IDLE, accept: 1'b0, ra_sel: RA_ZERO, re_a: 1'b0,
           rb_sel: RB_LAST_M, re_b: 1'b0, we: 1'b0, wa_sel: WA_IDX, wd_sel: WD_ELEM,
           idx_op: IDX_HOLD, elem_ld_rdb: 1'b0, m_op: M_HOLD, cnt_op: CNT_HOLD,
           drop_set: 1'b0, out_load: 1'b0};
    unique case (pc)
      // wait for a transfer; latch value, last mark and insert position
      ST_IDLE: begin
        cw.accept = 1'b1;
        cw.cond   = C_NO_INPUT;
        cw.target = ST_IDLE;
      end
      ST_CHK: begin
        cw.cond   = C_FULL;
        cw.target = ST_DROP;
      end
      // sift-up: read parent, stop at root
      ST_UP_READ: begin
        cw.re_a   = 1'b1;
        cw.ra_sel = RA_PARENT;
        cw.cond   = C_IDX_ZERO;
        cw.target = ST_UP_PLACE;
      end
      ST_UP_CMP: begin
        cw.cond   = C_NOT_GT;
        cw.target = ST_UP_PLACE;
      end
      ST_UP_MOVE: begin
        cw.we     = 1'b1;
        cw.wa_sel = WA_IDX;
        cw.wd_sel = WD_RDA;
        cw.idx_op = IDX_PARENT;
        cw.cond   = C_ALWAYS;
        cw.target = ST_UP_READ;
      end
      ST_UP_PLACE: begin
        cw.we     = 1'b1;
        cw.wa_sel = WA_IDX;
        cw.wd_sel = WD_ELEM;
        cw.cnt_op = CNT_INC;
        cw.cond   = C_ALWAYS;
        cw.target = ST_LAST;
      end
      ST_DROP: begin
        cw.drop_set = 1'b1;
      end
      ST_LAST: begin
        cw.cond   = C_NOT_LAST;
        cw.target = ST_IDLE;
      end
      // extraction: heap size starts at the item count
      ST_X_INIT: begin
        cw.m_op = M_LOAD;
      end
      ST_X_READ: begin
        cw.re_a   = 1'b1;
        cw.ra_sel = RA_ZERO;
        cw.re_b   = 1'b1;
        cw.rb_sel = RB_LAST_M;
        cw.cond   = C_SMALL;
        cw.target = ST_EM_INIT;
      end
      // move root to the end, take the last entry as the element to sink
      ST_X_SWAP: begin
        cw.we          = 1'b1;
        cw.wa_sel      = WA_LAST_M;
        cw.wd_sel      = WD_RDA;
        cw.elem_ld_rdb = 1'b1;
        cw.m_op        = M_DEC;
        cw.idx_op      = IDX_ZERO;
      end
      // sift-down: read both children
      ST_DN_READ: begin
        cw.re_a   = 1'b1;
        cw.ra_sel = RA_CHILD_L;
        cw.re_b   = 1'b1;
        cw.rb_sel = RB_CHILD_R;
        cw.cond   = C_NO_CHILD;
        cw.target = ST_DN_PLACE;
      end
      ST_DN_CMP: begin
        cw.cond   = C_NOT_GT_CHILD;
        cw.target = ST_DN_PLACE;
      end
      ST_DN_MOVE: begin
        cw.we     = 1'b1;
        cw.wa_sel = WA_IDX;
        cw.wd_sel = WD_CHILD;
        cw.idx_op = IDX_CHILD;
        cw.cond   = C_ALWAYS;
        cw.target = ST_DN_READ;
      end
      ST_DN_PLACE: begin
        cw.we     = 1'b1;
        cw.wa_sel = WA_IDX;
        cw.wd_sel = WD_ELEM;
        cw.cond   = C_ALWAYS;
        cw.target = ST_X_READ;
      end
      // emission: one store read per result, repeated while the output is stalled
      ST_EM_INIT: begin
        cw.idx_op = IDX_ZERO;
      end
      ST_EM_READ: begin
        cw.re_a   = 1'b1;
        cw.ra_sel = RA_IDX;
        cw.cond   = C_OUT_BUSY;
        cw.target = ST_EM_READ;
      end
      ST_EM_LOAD: begin
        cw.out_load = 1'b1;
        cw.idx_op   = IDX_INC;
        cw.cond     = C_MORE;
        cw.target   = ST_EM_READ;
      end
      ST_FIN: begin
        cw.cnt_op = CNT_CLR;
        cw.cond   = C_ALWAYS;
        cw.target = ST_IDLE;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

### rtl/hse_seq.sv
// ----------------------------------------------------------------------------
// hse_seq
// Microsequencer: step counter, control store lookup and conditional jump.
// ----------------------------------------------------------------------------
module hse_seq import hse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hse_flags_t flags_i,
  output hse_cw_t    cw_o
);

  pc_t     pc_q, pc_d;
  hse_cw_t cw;
  logic    take;

  // Fetch the control word of the current step
  assign cw   = hse_rom(pc_q);
  assign cw_o = cw;

  // Evaluate the branch condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_INPUT:     take = flags_i.no_input;
      C_FULL:         take = flags_i.full;
      C_IDX_ZERO:     take = flags_i.idx_zero;
      C_NOT_GT:       take = flags_i.not_gt;
      C_NOT_LAST:     take = flags_i.not_last;
      C_SMALL:        take = flags_i.small_heap;
      C_NO_CHILD:     take = flags_i.no_child;
      C_NOT_GT_CHILD: take = flags_i.not_gt_child;
      C_OUT_BUSY:     take = flags_i.out_busy;
      C_MORE:         take = flags_i.more;
      default:        take = 1'b1;
    endcase
  end

  // Jump or advance
  assign pc_d = take ? cw.target : pc_q + pc_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/hse_datapath.sv
// ----------------------------------------------------------------------------
// hse_datapath
// Heap store, index and size registers, compare logic and the result register,
// all steered by the control word.
// ----------------------------------------------------------------------------
module hse_datapath import hse_pkg::*; #(
  parameter int unsigned MAX_ITEMS = HSE_MAX_ITEMS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hse_cw_t                  cw_i,
  input  logic                     in_valid_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     is_last_i,
  output hse_flags_t               flags_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     last_result_o,
  output logic                     overflow_o
);

  localparam int unsigned AW    = $clog2(MAX_ITEMS);
  localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned XW    = AW + 2;
  localparam int unsigned DEPTH = 1 << AW;

  logic        [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rda_q, rdb_q;
  logic signed [DATA_W-1:0] elem_q, elem_d;
  logic        [AW-1:0]     idx_q, idx_d;
  logic        [CW-1:0]     cnt_q, cnt_d;
  logic        [CW-1:0]     m_q, m_d;
  logic                     last_q, last_d;
  logic                     drop_q, drop_d;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_last_q, out_ovf_q;

  logic                     take_in;
  logic        [AW-1:0]     parent, m_last, ra, rb, wa, child_idx;
  logic        [XW-1:0]     j_x, jr_x, m_x, cnt_x, idx_inc_x;
  logic                     use_r;
  logic signed [DATA_W-1:0] child, wd;

  assign take_in = cw_i.accept & in_valid_i;

  // Index arithmetic
  assign parent    = (idx_q - AW'(1)) >> 1;
  assign m_last    = AW'(m_q - CW'(1));
  assign j_x       = {1'b0, idx_q, 1'b1};
  assign jr_x      = j_x + XW'(1);
  assign m_x       = XW'(m_q);
  assign cnt_x     = XW'(cnt_q);
  assign idx_inc_x = XW'(idx_q) + XW'(1);

  // Pick the larger child; the right one only when strictly larger
  assign use_r     = (jr_x < m_x) && (rdb_q > rda_q);
  assign child     = use_r ? rdb_q : rda_q;
  assign child_idx = use_r ? jr_x[AW-1:0] : j_x[AW-1:0];

  // Address and data selection
  always_comb begin
    unique case (cw_i.ra_sel)
      RA_PARENT:  ra = parent;
      RA_ZERO:    ra = '0;
      RA_CHILD_L: ra = j_x[AW-1:0];
      RA_IDX:     ra = idx_q;
      default:    ra = '0;
    endcase
    rb = (cw_i.rb_sel == RB_CHILD_R) ? jr_x[AW-1:0] : m_last;
    wa = (cw_i.wa_sel == WA_LAST_M) ? m_last : idx_q;
    unique case (cw_i.wd_sel)
      WD_RDA:   wd = rda_q;
      WD_ELEM:  wd = elem_q;
      WD_CHILD: wd = child;
      default:  wd = elem_q;
    endcase
  end

  // Heap store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cw_i.we) begin
      mem_q[wa] <= wd;
    end
    if (cw_i.re_a) begin
      rda_q <= mem_q[ra];
    end
    if (cw_i.re_b) begin
      rdb_q <= mem_q[rb];
    end
  end

  // Next values of the working registers
  always_comb begin
    elem_d = elem_q;
    last_d = last_q;
    idx_d  = idx_q;
    if (take_in) begin
      elem_d = value_i;
      last_d = is_last_i;
      idx_d  = AW'(cnt_q);
    end else if (cw_i.elem_ld_rdb) begin
      elem_d = rdb_q;
    end
    case (cw_i.idx_op)
      IDX_PARENT: idx_d = parent;
      IDX_ZERO:   idx_d = '0;
      IDX_CHILD:  idx_d = child_idx;
      IDX_INC:    idx_d = idx_q + AW'(1);
      default:    ;
    endcase
    case (cw_i.m_op)
      M_LOAD:  m_d = cnt_q;
      M_DEC:   m_d = m_q - CW'(1);
      default: m_d = m_q;
    endcase
    // end of run clears the count and the overflow mark together
    case (cw_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
    drop_d = (cw_i.cnt_op == CNT_CLR) ? 1'b0 : (drop_q | cw_i.drop_set);
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    last_q <= last_d;
    idx_q  <= idx_d;
    m_q    <= m_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

  // Result register: load on emit, drop valid after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.out_load) begin
      out_value_q <= rda_q;
      out_last_q  <= !(idx_inc_x < cnt_x);
      out_ovf_q   <= drop_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_result_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

  // Status flags for the sequencer
  assign flags_o.no_input     = !in_valid_i;
  assign flags_o.full         = (cnt_q == CW'(MAX_ITEMS));
  assign flags_o.idx_zero     = (idx_q == '0);
  assign flags_o.not_gt       = !(elem_q > rda_q);
  assign flags_o.not_last     = !last_q;
  assign flags_o.small_heap   = (m_q <= CW'(1));
  assign flags_o.no_child     = (j_x >= m_x);
  assign flags_o.not_gt_child = !(child > elem_q);
  assign flags_o.out_busy     = out_valid_q & out_stall_i;
  assign flags_o.more         = (idx_inc_x < cnt_x);

  // Checks
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register loaded while a stalled result waits");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(drop_q) |-> cnt_q == CW'(MAX_ITEMS))
    else $error("overflow marked while the store had room");

  a_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_in |=> cnt_q == $past(cnt_q))
    else $error("count changed on the transfer cycle");

endmodule

### rtl/heap_sort_engine_core.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_core
// Insert: sift-up climbs at most log2 MAX_ITEMS heap levels, with a single store read
//   per compare-and-move step of the sequencer.
// Sort of n items: extractions sink level by level, then results are read out one by one.
// Throughput: one item at a time; input waits while a run is sorted and emitted.
// Reset: count and overflow mark clear at once; the store is not cleared.
// ----------------------------------------------------------------------------
module heap_sort_engine_core import hse_pkg::*; #(
  parameter int unsigned MAX_ITEMS = HSE_MAX_ITEMS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     is_last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     last_result_o,
  output logic                     overflow_o
);

  hse_cw_t    cw;
  hse_flags_t flags;

  // Sequencer
  hse_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  // Datapath
  hse_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cw_i           (cw),
    .in_valid_i     (in_valid_i),
    .value_i        (value_i),
    .is_last_i      (is_last_i),
    .flags_o        (flags),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .last_result_o  (last_result_o),
    .overflow_o     (overflow_o)
  );

  // Hold input off outside the wait step
  assign in_stall_o = !cw.accept;

endmodule
